// ===== sv/mssb_pkg.sv =====
// Shared types and constants of the multi-stack shared buffer.
`default_nettype none

package mssb_pkg;

	// Fixed field widths.
	localparam int DATA_W = 32;
	localparam int SID_W  = 3;

	// Parameter defaults for the top level.
	localparam int NUM_STACKS_DEF = 8;
	localparam int NUM_SLOTS_DEF  = 256;

	// Value returned by a pop that finds nothing.
	localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;

	// Operation codes.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Access strobes from the controller to the slot store.
	typedef struct packed {
		logic rd;
		logic wr_link;
		logic wr_value;
	} store_cmd_t;

endpackage

`default_nettype wire

// ===== sv/mssb_cmd_if.sv =====
// Command channel: one push or pop item per handshake.
`default_nettype none

interface mssb_cmd_if import mssb_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [SID_W-1:0]         stack_id;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output opcode, output stack_id, output push_value,
		input ready);
	modport sink (input valid, input opcode, input stack_id, input push_value,
		output ready);
endinterface

`default_nettype wire

// ===== sv/mssb_rsp_if.sv =====
// Response channel: one result item per command item.
`default_nettype none

interface mssb_rsp_if import mssb_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] pop_value;
	logic [1:0]               status;
	logic                     stack_empty;
	logic                     store_full;

	modport source (output valid, output pop_value, output status, output stack_empty,
		output store_full, input ready);
	modport sink (input valid, input pop_value, input status, input stack_empty,
		input store_full, output ready);
endinterface

`default_nettype wire

// ===== sv/mssb_slot_store.sv =====
// Slot store: value and link memories with a high-water mark for the initial free chain.
`default_nettype none

module mssb_slot_store
	import mssb_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire store_cmd_t                         cmd,
	input  wire logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
	input  wire logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
	input  wire logic [$clog2(NUM_SLOTS + 1)-1:0]   wr_link,
	input  wire logic [DATA_W-1:0]                  wr_value,
	output logic [$clog2(NUM_SLOTS + 1)-1:0]        rd_link,
	output logic [DATA_W-1:0]                       rd_value
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int LW = $clog2(NUM_SLOTS + 1);

	logic [LW-1:0]     link_mem [NUM_SLOTS];
	logic [DATA_W-1:0] value_mem [NUM_SLOTS];

	logic [LW-1:0]     link_rd_q;
	logic [DATA_W-1:0] value_rd_q;
	logic [SW-1:0]     rd_addr_q;
	logic              fresh_q;
	logic [LW-1:0]     hw_q;

	// Link memory: synchronous write, registered read.
	always_ff @(posedge clk) begin
		if (cmd.wr_link) begin
			link_mem[wr_addr] <= wr_link;
		end
		if (cmd.rd) begin
			link_rd_q <= link_mem[rd_addr];
		end
	end

	// Value memory: synchronous write, registered read.
	always_ff @(posedge clk) begin
		if (cmd.wr_value) begin
			value_mem[wr_addr] <= wr_value;
		end
		if (cmd.rd) begin
			value_rd_q <= value_mem[rd_addr];
			rd_addr_q  <= rd_addr;
		end
	end

	// Slots at or above the high-water mark have never had their link written.
	// Their link is still the reset chain, so it is formed from the address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q    <= '0;
			fresh_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				fresh_q <= (LW'(rd_addr) >= hw_q);
			end
			if (cmd.wr_link && (LW'(wr_addr) >= hw_q)) begin
				hw_q <= LW'(wr_addr) + LW'(1);
			end
		end
	end

	// The last slot links to the null code, which is exactly its address plus one.
	assign rd_link  = fresh_q ? (LW'(rd_addr_q) + LW'(1)) : link_rd_q;
	assign rd_value = value_rd_q;

	// The mark never passes the slot count.
	a_hw_range: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= LW'(NUM_SLOTS))
		else $error("high-water mark beyond slot count");

	// Fresh slots are handed out in order, so a first link write lands at the mark.
	a_fresh_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_link && (LW'(wr_addr) >= hw_q)) |-> (LW'(wr_addr) == hw_q))
		else $error("link written to a fresh slot out of order");

	// A read and a write never fall in the same cycle.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !(cmd.wr_link || cmd.wr_value))
		else $error("slot store read and write overlap");

endmodule

`default_nettype wire

// ===== sv/multi_stack_shared_buffer_top.sv =====
// Top level: several LIFO stacks linked through one shared slot store and a free list.
//
//  channel  role    payload                                            handshake
//  cmd      sink    opcode, stack_id, push_value                       valid/ready
//  rsp      source  pop_value, status, stack_empty, store_full         valid/ready
//
// Each item is handled in two parts: the accept cycle reads the slot's link and value
// from the slot store, and once the output register is free the work stage writes back
// and updates the heads and the free list. The slot store's read is registered; one
// item is in work. After reset every stack is empty and the free list starts at slot 0;
// no clearing pass is needed. A result waiting on rsp holds the work stage, and cmd
// stays low until it has been loaded into the output register.
`default_nettype none

module multi_stack_shared_buffer_top
	import mssb_pkg::*;
#(
	parameter int NUM_STACKS = NUM_STACKS_DEF,
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mssb_cmd_if.sink   cmd,
	mssb_rsp_if.source rsp
);

	localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int LW  = $clog2(NUM_SLOTS + 1);
	localparam int HIW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam logic [LW-1:0] NULL_LINK = LW'(NUM_SLOTS);

	// Head registers and free-list head.
	logic [LW-1:0] heads_q [NUM_STACKS];
	logic [LW-1:0] free_head_q;

	// Work stage.
	logic          busy_q;
	logic          op_s1;
	logic          sid_ok_s1;
	logic [HIW-1:0] hidx_s1;
	logic [DATA_W-1:0] val_s1;
	logic [LW-1:0] head_s1;
	logic [LW-1:0] slot_s1;
	logic          avail_s1;

	// Output register.
	logic              out_valid_q;
	logic [DATA_W-1:0] pop_value_q;
	status_t           status_q;
	logic              stack_empty_q;
	logic              store_full_q;

	logic          accept;
	logic          done;
	logic          sid_ok_c;
	logic [HIW-1:0] hidx_c;
	logic [LW-1:0] head_c;
	logic [LW-1:0] slot_c;
	logic          avail_c;

	store_cmd_t        st_cmd;
	logic [LW-1:0]     rd_link;
	logic [DATA_W-1:0] rd_value;
	logic [LW-1:0]     wr_link;

	logic [DATA_W-1:0] res_value;
	status_t           res_status;
	logic              res_empty;
	logic              res_full;

	// Address of the slot an incoming item works on.
	always_comb begin
		sid_ok_c = (32'(cmd.stack_id) < 32'(NUM_STACKS));
		hidx_c   = HIW'(cmd.stack_id);
		head_c   = sid_ok_c ? heads_q[hidx_c] : NULL_LINK;
		slot_c   = (cmd.opcode == OP_PUSH) ? free_head_q : head_c;
		avail_c  = sid_ok_c && (slot_c < NULL_LINK);
	end

	assign cmd.ready = !busy_q;
	assign accept    = cmd.valid && cmd.ready;
	assign done      = busy_q && (!out_valid_q || rsp.ready);

	// Slot store accesses: read on accept, write back when the stage completes.
	always_comb begin
		st_cmd.rd       = accept && avail_c;
		st_cmd.wr_link  = done && avail_s1;
		st_cmd.wr_value = done && avail_s1 && (op_s1 == OP_PUSH);
		wr_link         = (op_s1 == OP_PUSH) ? head_s1 : free_head_q;
	end

	mssb_slot_store #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (st_cmd),
		.rd_addr  (slot_c[SW-1:0]),
		.wr_addr  (slot_s1[SW-1:0]),
		.wr_link  (wr_link),
		.wr_value (val_s1),
		.rd_link  (rd_link),
		.rd_value (rd_value)
	);

	// Result of the item in the work stage.
	always_comb begin
		if (avail_s1) begin
			res_status = ST_OK;
			if (op_s1 == OP_PUSH) begin
				res_value = '0;
				res_empty = 1'b0;
				res_full  = (rd_link >= NULL_LINK);
			end else begin
				res_value = rd_value;
				res_empty = (rd_link >= NULL_LINK);
				res_full  = 1'b0;
			end
		end else begin
			res_status = (op_s1 == OP_PUSH) ? ST_OVERFLOW : ST_UNDERFLOW;
			res_value  = (op_s1 == OP_PUSH) ? '0 : MOST_NEG;
			res_empty  = sid_ok_s1 ? (head_s1 >= NULL_LINK) : 1'b1;
			res_full   = (free_head_q >= NULL_LINK);
		end
	end

	// Work stage capture on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= cmd.opcode;
			sid_ok_s1 <= sid_ok_c;
			hidx_s1   <= hidx_c;
			val_s1    <= cmd.push_value;
			head_s1   <= head_c;
			slot_s1   <= slot_c;
			avail_s1  <= avail_c;
		end
	end

	// Control, heads and free list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			free_head_q <= '0;
			for (int i = 0; i < NUM_STACKS; i++) begin
				heads_q[i] <= NULL_LINK;
			end
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done && avail_s1) begin
				if (op_s1 == OP_PUSH) begin
					heads_q[hidx_s1] <= slot_s1;
					free_head_q      <= rd_link;
				end else begin
					heads_q[hidx_s1] <= rd_link;
					free_head_q      <= slot_s1;
				end
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (done) begin
			pop_value_q   <= res_value;
			status_q      <= res_status;
			stack_empty_q <= res_empty;
			store_full_q  <= res_full;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.pop_value   = pop_value_q;
	assign rsp.status      = status_q;
	assign rsp.stack_empty = stack_empty_q;
	assign rsp.store_full  = store_full_q;

	// The free-list head is always a slot or the null code.
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= NULL_LINK)
		else $error("free-list head out of range");

	// Two items are never accepted on consecutive edges.
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !(cmd.valid && cmd.ready))
		else $error("item accepted while the previous one is in work");

	// A new result appears only after the work stage was occupied.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(busy_q))
		else $error("result without an item in work");

	// A successful push moves the free-list head along the link it read.
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done && avail_s1 && (op_s1 == OP_PUSH)) |=> (free_head_q == $past(rd_link)))
		else $error("free-list head not advanced on push");

endmodule

`default_nettype wire

// ===== dv/multi_stack_shared_buffer_top_tb.sv =====
// Testbench for the multi-stack shared buffer: predicts every result from the accepted commands.
`timescale 1ns / 100ps
`default_nettype none

module multi_stack_shared_buffer_top_tb;
	import mssb_pkg::*;

	localparam int NSTACKS      = NUM_STACKS_DEF;
	localparam int NSLOTS       = NUM_SLOTS_DEF;
	localparam int LINK_W       = $clog2(NSLOTS + 1);
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NSLOTS);
	localparam int RANDOM_ITEMS = 850;
	localparam int HOLD_CYCLES  = 60;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;

	// One expected result item.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		status_t           status;
		logic              empty;
		logic              full;
	} stack_result_t;

	// Linked stacks over one slot store, with the expected results still outstanding.
	class stack_checker;
		logic [DATA_W-1:0] slot_value [NSLOTS];
		logic [LINK_W-1:0] slot_next [NSLOTS];
		logic [LINK_W-1:0] stack_top [NSTACKS];
		logic [LINK_W-1:0] free_top;
		int                occupied;
		int                errors;
		stack_result_t     expected_results [$];

		function new();
			for (int i = 0; i < NSLOTS; i++) begin
				slot_value[i] = '0;
				slot_next[i]  = (i + 1 < NSLOTS) ? LINK_W'(i + 1) : NULL_LINK;
			end
			for (int s = 0; s < NSTACKS; s++)
				stack_top[s] = NULL_LINK;
			free_top = '0;
			occupied = 0;
			errors   = 0;
		endfunction

		function bit is_null(logic [LINK_W-1:0] link);
			return link >= LINK_W'(NSLOTS);
		endfunction

		function bit stack_is_empty(int s);
			return is_null(stack_top[s]);
		endfunction

		function bit store_is_full();
			return is_null(free_top);
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		// Apply one accepted command to the stacks and queue its result.
		function void note_command(logic op, logic [SID_W-1:0] sid, logic [DATA_W-1:0] val);
			stack_result_t     res;
			logic [LINK_W-1:0] slot;
			res.value  = '0;
			res.status = ST_OK;
			res.empty  = 1'b1;
			if (int'(sid) >= NSTACKS) begin
				if (op == OP_PUSH) begin
					res.status = ST_OVERFLOW;
				end else begin
					res.status = ST_UNDERFLOW;
					res.value  = MOST_NEG;
				end
			end else if (op == OP_PUSH) begin
				if (is_null(free_top)) begin
					res.status = ST_OVERFLOW;
				end else begin
					slot            = free_top;
					free_top        = slot_next[slot];
					slot_value[slot] = val;
					slot_next[slot] = stack_top[sid];
					stack_top[sid]  = slot;
					occupied++;
				end
				res.empty = is_null(stack_top[sid]);
			end else begin
				slot = stack_top[sid];
				if (is_null(slot)) begin
					res.status = ST_UNDERFLOW;
					res.value  = MOST_NEG;
				end else begin
					stack_top[sid]  = slot_next[slot];
					slot_next[slot] = free_top;
					free_top        = slot;
					res.value       = slot_value[slot];
					occupied--;
				end
				res.empty = is_null(stack_top[sid]);
			end
			res.full = is_null(free_top);
			expected_results.push_back(res);
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s", $realtime, msg);
		endfunction

		// Compare one accepted result item with the oldest expectation.
		function void check_result(logic [DATA_W-1:0] value, logic [1:0] status,
			logic empty, logic full);
			stack_result_t exp;
			if (expected_results.size() == 0) begin
				report($sformatf("result with no command outstanding: value %h status %0d",
					value, status));
				return;
			end
			exp = expected_results.pop_front();
			if (value !== exp.value || status !== exp.status || empty !== exp.empty ||
				full !== exp.full) begin
				report($sformatf({"result mismatch: expected value %h status %0d empty %b ",
					"full %b, got value %h status %0d empty %b full %b"},
					exp.value, exp.status, exp.empty, exp.full, value, status, empty, full));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   cmd_count = 0;
	stack_checker sb;

	mssb_cmd_if cmd_ch ();
	mssb_rsp_if rsp_ch ();

	multi_stack_shared_buffer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Gap before an item; some stretches run back to back.
	function automatic int draw_gap(int idx);
		return ((idx / 40) % 3 == 2) ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic logic [DATA_W-1:0] draw_value();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return MOST_NEG;
			3: return ~MOST_NEG;
			default: return $urandom;
		endcase
	endfunction

	// Offer one command item and wait until it is accepted. Called at a falling edge.
	task automatic send_command(input logic op, input logic [SID_W-1:0] sid,
		input logic [DATA_W-1:0] val);
		int gap;
		gap = draw_gap(cmd_count);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.opcode     <= op;
		cmd_ch.stack_id   <= sid;
		cmd_ch.push_value <= val;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		sb.note_command(op, sid, val);
		cmd_count++;
		@(negedge clk);
	endtask

	// Accept result items forever, with random stalls and two long hold-offs.
	task automatic collect_results();
		int n;
		int gap;
		n = 0;
		forever begin
			if (n == 100 || n == 600) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = draw_gap(n + 17);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_ch.valid);
			sb.check_result(rsp_ch.pop_value, rsp_ch.status, rsp_ch.stack_empty,
				rsp_ch.store_full);
			n++;
			@(negedge clk);
		end
	endtask

	// Value extremes, underflow, every stack pushed and popped.
	task automatic run_directed();
		send_command(OP_PUSH, 3'd0, ~MOST_NEG);
		send_command(OP_PUSH, 3'd0, MOST_NEG);
		send_command(OP_PUSH, 3'd7, '0);
		send_command(OP_PUSH, 3'd7, '1);
		send_command(OP_POP, 3'd7, '1);
		send_command(OP_POP, 3'd7, '0);
		send_command(OP_POP, 3'd7, '0);
		send_command(OP_POP, 3'd0, '1);
		send_command(OP_POP, 3'd0, '0);
		for (int s = 0; s < NSTACKS; s++)
			send_command(OP_PUSH, SID_W'(s), (s % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);
		for (int s = NSTACKS - 1; s >= 0; s--)
			send_command(OP_POP, SID_W'(s), $urandom);
	endtask

	// Alternate push-heavy phases that fill the store past full with pop-heavy
	// phases that drain it and then underflow.
	task automatic run_random(int n_items);
		bit               filling;
		int               linger;
		int               favorite;
		int               start;
		logic             op;
		logic [SID_W-1:0] sid;
		filling  = 1'b1;
		linger   = 0;
		favorite = 0;
		for (int i = 0; i < n_items; i++) begin
			if (filling)
				op = ($urandom_range(0, 9) < 9) ? OP_PUSH : OP_POP;
			else
				op = ($urandom_range(0, 9) < 9) ? OP_POP : OP_PUSH;
			if ($urandom_range(0, 15) == 0)
				favorite = $urandom_range(0, NSTACKS - 1);
			sid = $urandom_range(0, 1) ? SID_W'(favorite) : SID_W'($urandom_range(0, NSTACKS - 1));
			// While draining, aim most pops at a stack that still holds entries.
			if (!filling && op == OP_POP && $urandom_range(0, 3) != 0) begin
				start = $urandom_range(0, NSTACKS - 1);
				for (int k = 0; k < NSTACKS; k++) begin
					if (!sb.stack_is_empty((start + k) % NSTACKS)) begin
						sid = SID_W'((start + k) % NSTACKS);
						break;
					end
				end
			end
			send_command(op, sid, draw_value());
			if (filling && sb.store_is_full())
				linger++;
			else if (!filling && sb.occupied == 0)
				linger++;
			if (linger >= (filling ? 20 : 15)) begin
				filling = !filling;
				linger  = 0;
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.opcode     = OP_PUSH;
		cmd_ch.stack_id   = '0;
		cmd_ch.push_value = '0;
		rsp_ch.ready      = 1'b0;
		sb = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		fork
			collect_results();
		join_none
		run_directed();
		run_random(RANDOM_ITEMS);
		cmd_ch.valid <= 1'b0;
		// Drain the outstanding results, then let the block settle.
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== multi_stack_shared_buffer_top.f =====
sv/mssb_pkg.sv
sv/mssb_cmd_if.sv
sv/mssb_rsp_if.sv
sv/mssb_slot_store.sv
sv/multi_stack_shared_buffer_top.sv
dv/multi_stack_shared_buffer_top_tb.sv
